@@ rtl/pfrgba_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfrgba_pkg: shared types and constants for the pixel format converter
// Fixed-point format, source format codes, register indexes, YCbCr matrix
// coefficients and the 8-bit to normalized scale table.
// ----------------------------------------------------------------------------
package pfrgba_pkg;

  // Output fixed point: ONE = 1 << FRAC_BITS means 1.0 (legal range 8..14).
  localparam int FRAC_BITS = 12;
  localparam int ONE_VAL   = 1 << FRAC_BITS;
  localparam int HALF_VAL  = ONE_VAL / 2;

  // A scaled 8-bit sample lies in 0..ONE, so it needs FRAC_BITS + 1 bits.
  localparam int SCALE_W = FRAC_BITS + 1;

  // Matrix coefficients in Q4.14, signed.
  localparam int COEF_BITS = 14;
  localparam int COEF_W    = 18;
  // Accumulator: coefficient times a signed scaled sample, plus headroom for three terms.
  localparam int ACC_W     = COEF_W + SCALE_W + 1 + 2;

  localparam int FIELD_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 3;

  typedef enum logic [2:0] {
    FMT_L8        = 3'd0,
    FMT_LA8       = 3'd1,
    FMT_RGB8      = 3'd2,
    FMT_RGBA8     = 3'd3,
    FMT_RGB_FIX   = 3'd4,
    FMT_RGBA_FIX  = 3'd5,
    FMT_YCBCR     = 3'd6,
    FMT_UNSUPPORT = 3'd7
  } src_fmt_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SOURCE_FORMAT = 2'd0,
    CFG_YUV_RANGE     = 2'd1
  } cfg_idx_e;

  localparam logic signed [COEF_W-1:0] K_FULL_Y   = 18'sd16384;
  localparam logic signed [COEF_W-1:0] K_FULL_RCR = 18'sd22938;
  localparam logic signed [COEF_W-1:0] K_FULL_GCB = -18'sd5620;
  localparam logic signed [COEF_W-1:0] K_FULL_GCR = -18'sd11649;
  localparam logic signed [COEF_W-1:0] K_FULL_BCB = 18'sd28918;
  localparam logic signed [COEF_W-1:0] K_VID_Y    = 18'sd19071;
  localparam logic signed [COEF_W-1:0] K_VID_RCR  = 18'sd29377;
  localparam logic signed [COEF_W-1:0] K_VID_GCB  = -18'sd3490;
  localparam logic signed [COEF_W-1:0] K_VID_GCR  = -18'sd8733;
  localparam logic signed [COEF_W-1:0] K_VID_BCB  = 18'sd34603;

  typedef logic [SCALE_W-1:0] scale_lut_t [256];

  // floor((s * ONE + 127) / 255), evaluated at elaboration.
  function automatic scale_lut_t build_scale_lut();
    scale_lut_t lut;
    for (int s = 0; s < 256; s++) begin
      lut[s] = SCALE_W'((s * ONE_VAL + 127) / 255);
    end
    return lut;
  endfunction

  localparam scale_lut_t SCALE_LUT = build_scale_lut();

endpackage

@@ rtl/pixel_format_to_rgba.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_format_to_rgba: pixel format to normalized RGBA converter
// Turns one pixel word into red, green, blue and alpha in signed fixed point
// with FRAC_BITS fraction bits, following the configured source format.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+------------------------------
//  input    | sink      | in_valid_i/in_ready_o  | chan0_i..chan3_i (s16 each)
//  output   | source    | out_valid_o/out_ready_i| red_o, green_o, blue_o, alpha_o
//  config   | sink      | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
//  One word per clock when the output side keeps up; a word taken sits in
//  the input register, moves on to the result register and leaves from there.
//  The scale table lookup, the matrix multiplies and the round/saturate sit
//  between those two registers. Reset empties both stages and loads the
//  registers with RGBA8 and full range. A stall on the output holds the
//  result and, once the input register is also full, drops in_ready_o.
//  Config writes are always taken.
// ----------------------------------------------------------------------------
module pixel_format_to_rgba
  import pfrgba_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input words
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [FIELD_W-1:0]   chan0_i,
  input  logic signed [FIELD_W-1:0]   chan1_i,
  input  logic signed [FIELD_W-1:0]   chan2_i,
  input  logic signed [FIELD_W-1:0]   chan3_i,
  // result words
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [FIELD_W-1:0]   red_o,
  output logic signed [FIELD_W-1:0]   green_o,
  output logic signed [FIELD_W-1:0]   blue_o,
  output logic signed [FIELD_W-1:0]   alpha_o,
  // configuration writes
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [CFG_DAT_W-1:0]        cfg_data_i
);

  localparam logic signed [FIELD_W-1:0] ONE_FIX  = FIELD_W'(ONE_VAL);
  localparam logic signed [SCALE_W:0]   HALF_FIX = (SCALE_W + 1)'(HALF_VAL);
  localparam logic signed [ACC_W-1:0]   ROUND_HALF = ACC_W'(1) << (COEF_BITS - 1);
  localparam logic signed [ACC_W-1:0]   SAT_MAX = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0]   SAT_MIN = -ACC_W'(32768);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  src_fmt_e fmt_q;
  logic     yuv_range_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q       <= FMT_RGBA8;
      yuv_range_q <= 1'b0;
    end else if (cfg_valid_i) begin
      // Indexes past the register list are dropped.
      unique case (cfg_index_i)
        CFG_SOURCE_FORMAT: fmt_q       <= src_fmt_e'(cfg_data_i);
        CFG_YUV_RANGE:     yuv_range_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake: two-entry pipeline, each stage advances when the next is free
  // --------------------------------------------------------------------------
  logic in_valid_q;
  logic out_valid_q;
  logic out_free;
  logic in_load;
  logic out_load;

  assign out_free   = !out_valid_q || out_ready_i;
  assign out_load   = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;
  assign in_load    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // Input register: hold the accepted word until it moves to the result stage.
  logic signed [FIELD_W-1:0] ch0_q, ch1_q, ch2_q, ch3_q;

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      ch0_q <= chan0_i;
      ch1_q <= chan1_i;
      ch2_q <= chan2_i;
      ch3_q <= chan3_i;
    end
  end

  // --------------------------------------------------------------------------
  // Conversion datapath
  // --------------------------------------------------------------------------
  // 8-bit samples: only the low byte counts.
  logic [SCALE_W-1:0] s0, s1, s2, s3;

  assign s0 = SCALE_LUT[ch0_q[7:0]];
  assign s1 = SCALE_LUT[ch1_q[7:0]];
  assign s2 = SCALE_LUT[ch2_q[7:0]];
  assign s3 = SCALE_LUT[ch3_q[7:0]];

  // YCbCr: luma as is, chroma centered on zero.
  logic signed [SCALE_W:0] y_s, cb_s, cr_s;

  assign y_s  = signed'({1'b0, s0});
  assign cb_s = signed'({1'b0, s1}) - HALF_FIX;
  assign cr_s = signed'({1'b0, s2}) - HALF_FIX;

  logic signed [COEF_W-1:0] k_y, k_rcr, k_gcb, k_gcr, k_bcb;

  always_comb begin
    if (yuv_range_q) begin
      k_y   = K_VID_Y;
      k_rcr = K_VID_RCR;
      k_gcb = K_VID_GCB;
      k_gcr = K_VID_GCR;
      k_bcb = K_VID_BCB;
    end else begin
      k_y   = K_FULL_Y;
      k_rcr = K_FULL_RCR;
      k_gcb = K_FULL_GCB;
      k_gcr = K_FULL_GCR;
      k_bcb = K_FULL_BCB;
    end
  end

  logic signed [ACC_W-1:0] p_y, p_rcr, p_gcb, p_gcr, p_bcb;
  logic signed [ACC_W-1:0] acc_r, acc_g, acc_b;
  logic signed [ACC_W-1:0] rnd_r, rnd_g, rnd_b;

  assign p_y   = ACC_W'(k_y) * ACC_W'(y_s);
  assign p_rcr = ACC_W'(k_rcr) * ACC_W'(cr_s);
  assign p_gcb = ACC_W'(k_gcb) * ACC_W'(cb_s);
  assign p_gcr = ACC_W'(k_gcr) * ACC_W'(cr_s);
  assign p_bcb = ACC_W'(k_bcb) * ACC_W'(cb_s);

  // Round half up, then drop the coefficient fraction.
  assign acc_r = p_y + p_rcr + ROUND_HALF;
  assign acc_g = p_y + p_gcb + p_gcr + ROUND_HALF;
  assign acc_b = p_y + p_bcb + ROUND_HALF;

  assign rnd_r = acc_r >>> COEF_BITS;
  assign rnd_g = acc_g >>> COEF_BITS;
  assign rnd_b = acc_b >>> COEF_BITS;

  function automatic logic signed [FIELD_W-1:0] sat16(logic signed [ACC_W-1:0] v);
    logic signed [FIELD_W-1:0] res;
    if (v > SAT_MAX) begin
      res = 16'sh7FFF;
    end else if (v < SAT_MIN) begin
      res = 16'sh8000;
    end else begin
      res = v[FIELD_W-1:0];
    end
    return res;
  endfunction

  logic signed [FIELD_W-1:0] yr, yg, yb;
  logic signed [FIELD_W-1:0] l0, l1, l2, l3;

  assign yr = sat16(rnd_r);
  assign yg = sat16(rnd_g);
  assign yb = sat16(rnd_b);

  assign l0 = FIELD_W'(s0);
  assign l1 = FIELD_W'(s1);
  assign l2 = FIELD_W'(s2);
  assign l3 = FIELD_W'(s3);

  logic signed [FIELD_W-1:0] red_d, green_d, blue_d, alpha_d;

  always_comb begin
    case (fmt_q) inside
      FMT_L8, FMT_LA8: begin
        red_d   = l0;
        green_d = l0;
        blue_d  = l0;
      end
      FMT_RGB8, FMT_RGBA8: begin
        red_d   = l0;
        green_d = l1;
        blue_d  = l2;
      end
      FMT_RGB_FIX, FMT_RGBA_FIX: begin
        red_d   = ch0_q;
        green_d = ch1_q;
        blue_d  = ch2_q;
      end
      FMT_YCBCR: begin
        red_d   = yr;
        green_d = yg;
        blue_d  = yb;
      end
      default: begin
        red_d   = '0;
        green_d = '0;
        blue_d  = '0;
      end
    endcase

    case (fmt_q) inside
      FMT_L8, FMT_RGB8, FMT_RGB_FIX, FMT_YCBCR: alpha_d = ONE_FIX;
      FMT_LA8:                                  alpha_d = l1;
      FMT_RGBA8:                                alpha_d = l3;
      FMT_RGBA_FIX:                             alpha_d = ch3_q;
      default:                                  alpha_d = '0;
    endcase
  end

  // Result register: advance only when the output side is free.
  logic signed [FIELD_W-1:0] red_q, green_q, blue_q, alpha_q;

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
      alpha_q <= alpha_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;
  assign alpha_o     = alpha_q;

endmodule

@@ tb/pixel_format_to_rgba_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_format_to_rgba_checker: result checker for the pixel format converter
// Watches the input, result and configuration channels, computes the RGBA
// word that each accepted pixel word must turn into, and compares it field
// by field with the result words in order.
// ----------------------------------------------------------------------------
module pixel_format_to_rgba_checker
  import pfrgba_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic signed [FIELD_W-1:0] chan0_i,
  input  logic signed [FIELD_W-1:0] chan1_i,
  input  logic signed [FIELD_W-1:0] chan2_i,
  input  logic signed [FIELD_W-1:0] chan3_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic signed [FIELD_W-1:0] red_i,
  input  logic signed [FIELD_W-1:0] green_i,
  input  logic signed [FIELD_W-1:0] blue_i,
  input  logic signed [FIELD_W-1:0] alpha_i,
  input  logic                      cfg_valid_i,
  input  logic                      cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [CFG_DAT_W-1:0]      cfg_data_i,
  output int                        fail_count_o,
  output int                        pending_o
);

  localparam longint UNIT     = longint'(1) << FRAC_BITS;
  localparam int     MAT_FRAC = 14;

  // Matrix weights in Q4.14, rounded from the decimal coefficients.
  localparam longint FULL_Y   = 16384;   // 1.0
  localparam longint FULL_RCR = 22938;   // 1.4
  localparam longint FULL_GCB = -5620;   // -0.343
  localparam longint FULL_GCR = -11649;  // -0.711
  localparam longint FULL_BCB = 28918;   // 1.765
  localparam longint VID_Y    = 19071;   // 1.164
  localparam longint VID_RCR  = 29377;   // 1.793
  localparam longint VID_GCB  = -3490;   // -0.213
  localparam longint VID_GCR  = -8733;   // -0.533
  localparam longint VID_BCB  = 34603;   // 2.112

  typedef struct packed {
    logic signed [FIELD_W-1:0] red;
    logic signed [FIELD_W-1:0] green;
    logic signed [FIELD_W-1:0] blue;
    logic signed [FIELD_W-1:0] alpha;
  } rgba_word_t;

  src_fmt_e   src_fmt;
  logic       video_range;
  rgba_word_t expected_rgba_q[$];
  rgba_word_t want;
  int         mismatches = 0;

  // Only the low byte of an 8-bit sample counts.
  function automatic longint norm8(logic [FIELD_W-1:0] raw);
    longint s;
    s = longint'(raw[7:0]);
    return ((s << FRAC_BITS) + 127) / 255;
  endfunction

  // Round half up by the matrix shift, then saturate to 16 bits.
  function automatic logic signed [FIELD_W-1:0] mat_round(longint acc);
    longint r;
    r = (acc + (longint'(1) << (MAT_FRAC - 1))) >>> MAT_FRAC;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return FIELD_W'(r);
  endfunction

  function automatic rgba_word_t convert_pixel(src_fmt_e fmt, logic video,
                                               logic [FIELD_W-1:0] c0,
                                               logic [FIELD_W-1:0] c1,
                                               logic [FIELD_W-1:0] c2,
                                               logic [FIELD_W-1:0] c3);
    rgba_word_t w;
    longint     y;
    longint     cb;
    longint     cr;
    w = '0;
    case (fmt)
      FMT_L8, FMT_LA8: begin
        w.red   = FIELD_W'(norm8(c0));
        w.green = w.red;
        w.blue  = w.red;
        w.alpha = (fmt == FMT_LA8) ? FIELD_W'(norm8(c1)) : FIELD_W'(UNIT);
      end
      FMT_RGB8, FMT_RGBA8: begin
        w.red   = FIELD_W'(norm8(c0));
        w.green = FIELD_W'(norm8(c1));
        w.blue  = FIELD_W'(norm8(c2));
        w.alpha = (fmt == FMT_RGBA8) ? FIELD_W'(norm8(c3)) : FIELD_W'(UNIT);
      end
      FMT_RGB_FIX, FMT_RGBA_FIX: begin
        w.red   = c0;
        w.green = c1;
        w.blue  = c2;
        w.alpha = (fmt == FMT_RGBA_FIX) ? c3 : FIELD_W'(UNIT);
      end
      FMT_YCBCR: begin
        y  = norm8(c0);
        cb = norm8(c1) - UNIT / 2;
        cr = norm8(c2) - UNIT / 2;
        if (video) begin
          w.red   = mat_round(VID_Y * y + VID_RCR * cr);
          w.green = mat_round(VID_Y * y + VID_GCB * cb + VID_GCR * cr);
          w.blue  = mat_round(VID_Y * y + VID_BCB * cb);
        end else begin
          w.red   = mat_round(FULL_Y * y + FULL_RCR * cr);
          w.green = mat_round(FULL_Y * y + FULL_GCB * cb + FULL_GCR * cr);
          w.blue  = mat_round(FULL_Y * y + FULL_BCB * cb);
        end
        w.alpha = FIELD_W'(UNIT);
      end
      default: begin
        w = '0;
      end
    endcase
    return w;
  endfunction

  task automatic check_field(string name, logic signed [FIELD_W-1:0] exp_v,
                             logic signed [FIELD_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_fmt     <= FMT_RGBA8;
      video_range <= 1'b0;
      expected_rgba_q.delete();
      pending_o    <= 0;
      fail_count_o <= mismatches;
    end else begin
      // Append the predicted word at the tail of the queue.
      if (in_valid_i && in_ready_i) begin
        expected_rgba_q = {expected_rgba_q,
                           convert_pixel(src_fmt, video_range,
                                         chan0_i, chan1_i, chan2_i, chan3_i)};
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_rgba_q.size() == 0) begin
          $error("result word with no pixel word waiting: %0d %0d %0d %0d",
                 red_i, green_i, blue_i, alpha_i);
          mismatches++;
        end else begin
          want = expected_rgba_q.pop_front();
          check_field("red", want.red, red_i);
          check_field("green", want.green, green_i);
          check_field("blue", want.blue, blue_i);
          check_field("alpha", want.alpha, alpha_i);
        end
      end
      // Indexes past the two registers are dropped.
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_SOURCE_FORMAT: src_fmt     <= src_fmt_e'(cfg_data_i);
          CFG_YUV_RANGE:     video_range <= cfg_data_i[0];
          default: ;
        endcase
      end
      pending_o    <= expected_rgba_q.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

@@ tb/pixel_format_to_rgba_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_format_to_rgba_tb: stimulus and verdict for the pixel format converter
// Runs a directed pass over every source format, the matrix ranges and the
// register corner cases, then random pixel words under each format with
// random gaps on both sides in all but two phases. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module pixel_format_to_rgba_tb;
  import pfrgba_pkg::*;

  localparam int          RESET_CYCLES = 10;
  localparam int          SETTLE_CYCLES = 10;
  localparam int          WORDS_PER_PHASE = 90;
  localparam int          PHASES = 16;
  localparam int          IDLE_PCT = 15;
  localparam longint      TIMEOUT_NS = 2_000_000;
  // Register indexes that hold no register: writes there must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic signed [FIELD_W-1:0] chan0;
  logic signed [FIELD_W-1:0] chan1;
  logic signed [FIELD_W-1:0] chan2;
  logic signed [FIELD_W-1:0] chan3;
  logic                      out_valid;
  logic                      out_ready;
  logic signed [FIELD_W-1:0] red;
  logic signed [FIELD_W-1:0] green;
  logic signed [FIELD_W-1:0] blue;
  logic signed [FIELD_W-1:0] alpha;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_DAT_W-1:0]      cfg_data;
  int                        fail_count;
  int                        pending;
  // Clear to run a stretch with both sides streaming back to back.
  logic                      idle_on;

  pixel_format_to_rgba dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .chan0_i     (chan0),
    .chan1_i     (chan1),
    .chan2_i     (chan2),
    .chan3_i     (chan3),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .red_o       (red),
    .green_o     (green),
    .blue_o      (blue),
    .alpha_o     (alpha),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  pixel_format_to_rgba_checker rgba_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .chan0_i      (chan0),
    .chan1_i      (chan1),
    .chan2_i      (chan2),
    .chan3_i      (chan3),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .red_i        (red),
    .green_i      (green),
    .blue_i       (blue),
    .alpha_i      (alpha),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // 8 ns period: 4 ns high, 4 ns low.
  initial begin
    clk = 1'b0;
  end

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver: stall in roughly one cycle of seven unless idling is off.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !idle_on || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Hang guard: no correct run comes anywhere near this.
  initial begin
    #(TIMEOUT_NS);
    $display("Test completed with failures");
    $finish;
  end

  // Offer one pixel word and hold it until the block takes it. Random gaps
  // go in front of the word, so valid drops only when a gap is chosen or a drain starts.
  task automatic send_pixel(logic [FIELD_W-1:0] c0, logic [FIELD_W-1:0] c1,
                            logic [FIELD_W-1:0] c2, logic [FIELD_W-1:0] c3);
    while (idle_on && ($urandom_range(0, 99) < IDLE_PCT)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    chan0    <= c0;
    chan1    <= c1;
    chan2    <= c2;
    chan3    <= c3;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop sending and hold until every result word has come back. Each pixel
  // word makes exactly one result, so an empty checker means an empty pipe.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Register writes go in only while the pipe is empty.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Mix of in-range 8-bit samples, extremes and fully random 16-bit values,
  // so stray high bits in 8-bit formats and every bit of each field get hit.
  function automatic logic [FIELD_W-1:0] rand_chan();
    logic [FIELD_W-1:0] v;
    case ($urandom_range(0, 5))
      0, 1: v = FIELD_W'($urandom_range(0, 255));
      2: begin
        case ($urandom_range(0, 4))
          0: v = 16'h0000;
          1: v = 16'h00FF;
          2: v = 16'h7FFF;
          3: v = 16'h8000;
          default: v = 16'hFFFF;
        endcase
      end
      default: v = FIELD_W'($urandom);
    endcase
    return v;
  endfunction

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    chan0     = '0;
    chan1     = '0;
    chan2     = '0;
    chan3     = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    idle_on   = 1'b1;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset format is RGBA8, full range; run it before any write.
    send_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_pixel(16'h00FF, 16'h00FF, 16'h00FF, 16'h00FF);
    // High bits of 8-bit samples must be dropped.
    send_pixel(16'h7FFF, 16'h8000, 16'hFFFF, 16'h0180);
    send_pixel(16'h0001, 16'h0080, 16'h007F, 16'h00FE);
    // A write to an index with no register changes nothing.
    write_reg(CFG_SPARE_LO, 3'd7);
    send_pixel(16'h00FF, 16'h0000, 16'h0080, 16'h0040);

    write_reg(CFG_SOURCE_FORMAT, FMT_L8);
    send_pixel(16'h00FF, 16'h004D, 16'h004D, 16'h004D);
    send_pixel(16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    write_reg(CFG_SOURCE_FORMAT, FMT_LA8);
    send_pixel(16'h00C8, 16'hFF03, 16'h1234, 16'h5678);
    write_reg(CFG_SOURCE_FORMAT, FMT_RGB8);
    send_pixel(16'h000A, 16'h0014, 16'h001E, 16'h0028);
    write_reg(CFG_SOURCE_FORMAT, FMT_RGB_FIX);
    send_pixel(16'h8000, 16'h7FFF, 16'hFFFF, 16'h04D2);
    write_reg(CFG_SOURCE_FORMAT, FMT_RGBA_FIX);
    send_pixel(16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF);
    send_pixel(16'h8000, 16'h0001, 16'h1000, 16'h7FFF);

    // YCbCr, full range: all samples low, all high, the chroma corners and mid grey.
    write_reg(CFG_SOURCE_FORMAT, FMT_YCBCR);
    send_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_pixel(16'h00FF, 16'h00FF, 16'h00FF, 16'h00FF);
    send_pixel(16'h00FF, 16'h0000, 16'h00FF, 16'h0000);
    send_pixel(16'h0000, 16'h00FF, 16'h0000, 16'hFFFF);
    send_pixel(16'h0080, 16'h0080, 16'h0080, 16'h0080);
    // Video range.
    write_reg(CFG_YUV_RANGE, 3'd1);
    send_pixel(16'h00FF, 16'h00FF, 16'h00FF, 16'h0000);
    send_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_pixel(16'h00FF, 16'h0000, 16'h00FF, 16'h0000);
    // Upper data bits beyond the one-bit register are masked: back to full.
    write_reg(CFG_YUV_RANGE, 3'b110);
    send_pixel(16'h00FF, 16'h0000, 16'h00FF, 16'h0000);
    write_reg(CFG_SPARE_HI, 3'd5);

    // Unsupported format: every field, alpha too, reads zero.
    write_reg(CFG_SOURCE_FORMAT, FMT_UNSUPPORT);
    send_pixel(16'h00FF, 16'h00FF, 16'h00FF, 16'h00FF);

    // Random phases: each format under both range settings, with random
    // upper data bits on the range write and the odd dead-index write.
    for (int p = 0; p < PHASES; p++) begin
      // Phases five and six stream with no gaps on either side.
      idle_on = !(p == 5 || p == 6);
      write_reg(CFG_SOURCE_FORMAT, CFG_DAT_W'(p % 8));
      write_reg(CFG_YUV_RANGE, {2'($urandom_range(0, 3)), 1'(p / 8)});
      if ($urandom_range(0, 3) == 0) begin
        write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                  CFG_DAT_W'($urandom));
      end
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        send_pixel(rand_chan(), rand_chan(), rand_chan(), rand_chan());
      end
    end
    idle_on = 1'b1;

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/pfrgba_pkg.sv
rtl/pixel_format_to_rgba.sv
tb/pixel_format_to_rgba_checker.sv
tb/pixel_format_to_rgba_tb.sv
